>>> rtl/pidsa_pkg.sv
package pidsa_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegKp     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKi     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKd     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPvW    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDerivW = 3'd6;
  localparam logic [CfgIdxW-1:0] RegInvert = 3'd7;

  // datapath steps issued by the controller
  typedef enum logic [3:0] {
    OpIdle,
    OpLoad,
    OpOpen,
    OpPvMul,
    OpPvRnd,
    OpErr,
    OpPMul,
    OpLoDivSt,
    OpLoDivEnd,
    OpHiDivSt,
    OpHiDivEnd,
    OpIntUpd,
    OpIMul,
    OpDDivSt,
    OpDDivEnd,
    OpFinish
  } op_e;

  typedef struct packed {
    op_e  op;
    logic mul_a;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic is_open;
  } sts_t;

endpackage

>>> rtl/pidsa_div.sv
// 80/64 signed divider, restoring, one quotient bit per cycle, truncating
module pidsa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [79:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               busy_o,
  output logic signed [79:0] quo_o
);
  logic [79:0] q_q, q_d;
  logic [63:0] r_q, r_d;
  logic [63:0] d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic        busy_q, busy_d;
  logic [64:0] sh;
  logic [65:0] diff;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q;
    sh   = {r_q, q_q[79]};
    diff = {1'b0, sh} - {2'b00, d_q};
    if (start_i) begin
      q_d    = num_i[79] ? 80'(-num_i) : num_i;
      d_d    = den_i[63] ? 64'(-den_i) : den_i;
      neg_d  = num_i[79] ^ den_i[63];
      r_d    = '0;
      cnt_d  = 7'd80;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[65]) begin
        r_d = diff[63:0];
        q_d = {q_q[78:0], 1'b1};
      end else begin
        r_d = sh[63:0];
        q_d = {q_q[78:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d; neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? 80'(-q_q) : q_q;
endmodule

>>> rtl/pidsa_dp.sv
module pidsa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidsa_pkg::cmd_t     cmd_i,
  output pidsa_pkg::sts_t     sts_o,
  input  logic [31:0]         kp_i,
  input  logic [31:0]         ki_i,
  input  logic [31:0]         kd_i,
  input  logic [31:0]         omin_i,
  input  logic [31:0]         omax_i,
  input  logic [16:0]         pvw_i,
  input  logic [16:0]         dw_i,
  input  logic                inv_i,
  input  logic [129:0]        in_i,
  output logic [127:0]        res_o
);
  logic signed [31:0] sp_q, pv_q, olv_q;
  logic [30:0] dt_q;
  logic signed [1:0] lim_q;
  logic op_q;
  logic signed [31:0] pvs_q, lerr_q, isum_q, ds_q;
  logic was_open_q;
  logic signed [31:0] err_q, p_q, i_q, lo_q, hi_q, drv_q;
  logic signed [63:0] mul_q, acc_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  logic div_start, div_busy;
  logic signed [79:0] div_num, div_quo;
  logic signed [63:0] div_den;

  function automatic logic signed [31:0] sat(input logic signed [81:0] x);
    if (x > 82'sd2147483647) return 32'sh7fffffff;
    if (x < -82'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'sd32768;
    return y >>> 16;
  endfunction

  function automatic logic signed [31:0] clmp(input logic signed [47:0] x,
      input logic signed [31:0] lo, input logic signed [31:0] hi);
    if (x < 48'(lo)) return lo;
    if (x < 48'(hi)) return x[31:0];
    return hi;
  endfunction

  logic [16:0] pw, dw;
  assign pw = pvw_i[16] ? 17'h10000 : pvw_i;
  assign dw = dw_i[16] ? 17'h10000 : dw_i;

  // zero time step counts as one
  logic signed [32:0] derr;
  logic [31:0] dtn;
  assign derr = 33'(err_q) - 33'(lerr_q);
  assign dtn  = (dt_q == '0) ? 32'd1 : {1'b0, dt_q};

  // shared multiplier operands
  always_comb begin
    ma = '0; mb = '0;
    case (cmd_i.op)
      pidsa_pkg::OpPvMul: begin
        ma = cmd_i.mul_a ? pv_q : pvs_q;
        mb = cmd_i.mul_a ? 32'(pw) : 32'(18'h10000 - 18'(pw));
      end
      pidsa_pkg::OpPMul: begin ma = kp_i; mb = err_q; end
      pidsa_pkg::OpLoDivSt: begin ma = dtn; mb = err_q; end
      pidsa_pkg::OpIMul: begin ma = ki_i; mb = isum_q; end
      pidsa_pkg::OpDDivEnd: begin
        ma = cmd_i.mul_a ? sat(82'(div_quo)) : ds_q;
        mb = cmd_i.mul_a ? 32'(dw) : 32'(18'h10000 - 18'(dw));
      end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  always_comb begin
    div_start = 1'b0; div_num = '0; div_den = '0;
    case (cmd_i.op)
      pidsa_pkg::OpLoDivSt: begin
        div_start = 1'b1; div_num = 80'($signed(omin_i)) <<< 16; div_den = 64'($signed(ki_i));
      end
      pidsa_pkg::OpHiDivSt: begin
        div_start = 1'b1; div_num = 80'($signed(omax_i)) <<< 16; div_den = 64'($signed(ki_i));
      end
      pidsa_pkg::OpDDivSt: begin
        div_start = 1'b1; div_num = 80'(mul_q); div_den = 64'({dtn, 1'b0});
      end
      default: ;
    endcase
  end

  pidsa_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  logic signed [47:0] tsum;
  logic signed [31:0] cl;
  logic frz;
  assign frz = (lim_q != 2'sd0) && (err_q != 0) && (isum_q != 0)
               && (err_q[31] == lim_q[1]) && (isum_q[31] == lim_q[1]);
  assign tsum = 48'(rnd(acc_q)) + 48'(isum_q);
  always_comb begin
    cl = clmp(48'(p_q) + 48'(i_q) + 48'(ds_q), omin_i, omax_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvs_q <= '0; lerr_q <= '0; isum_q <= '0; ds_q <= '0; was_open_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        pidsa_pkg::OpOpen: begin
          if (!was_open_q) begin
            pvs_q <= pv_q; ds_q <= '0; isum_q <= lerr_q;
          end
          was_open_q <= 1'b1;
        end
        pidsa_pkg::OpPvRnd: begin
          pvs_q <= 32'(rnd(mul_q + acc_q));
          was_open_q <= 1'b0;
        end
        pidsa_pkg::OpIntUpd: if (!frz) isum_q <= clmp(tsum, lo_q, hi_q);
        pidsa_pkg::OpFinish: begin
          // open loop keeps the last error
          if (!op_q) lerr_q <= err_q;
          if (!cmd_i.mul_a) ds_q <= 32'(rnd(mul_q + acc_q));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pidsa_pkg::OpLoad: begin
        sp_q <= in_i[31:0]; pv_q <= in_i[63:32]; dt_q <= in_i[94:64];
        lim_q <= (in_i[96:95] == 2'b10) ? 2'sb11 : in_i[96:95];
        op_q <= in_i[97]; olv_q <= in_i[129:98];
      end
      pidsa_pkg::OpPvMul: begin
        if (cmd_i.mul_a) acc_q <= mp; else mul_q <= mp;
      end
      pidsa_pkg::OpErr: err_q <= sat(82'(sp_q) - 82'(pvs_q));
      pidsa_pkg::OpPMul: p_q <= sat(82'(rnd(mp)));
      pidsa_pkg::OpLoDivSt: acc_q <= mp;
      pidsa_pkg::OpLoDivEnd: lo_q <= (ki_i == 0) ? 32'sd0 : sat(82'(div_quo));
      pidsa_pkg::OpHiDivEnd: hi_q <= (ki_i == 0) ? 32'sd0 : sat(82'(div_quo));
      pidsa_pkg::OpIntUpd: mul_q <= 64'($signed(kd_i)) * 64'(derr);
      pidsa_pkg::OpIMul: i_q <= sat(82'(rnd(mp)));
      pidsa_pkg::OpDDivEnd: begin
        if (cmd_i.mul_a) mul_q <= mp; else acc_q <= mp;
      end
      pidsa_pkg::OpFinish: if (cmd_i.mul_a) begin
        drv_q <= op_q ? olv_q : (inv_i ? sat(-82'(cl)) : cl);
      end
      default: ;
    endcase
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.is_open  = op_q;
  assign res_o = op_q ? {96'd0, olv_q} : {ds_q, i_q, p_q, drv_q};
endmodule

>>> rtl/pidsa_ctrl.sv
module pidsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pidsa_pkg::sts_t sts_i,
  output pidsa_pkg::cmd_t cmd_o
);
  typedef enum logic [4:0] {
    StIdle, StLoad, StOpen, StPvA, StPvB, StPvR, StErr, StPMul, StLoSt, StLoW, StHiSt,
    StHiW, StInt, StIMul, StDSt, StDW, StDB, StFin, StSmooth, StOut
  } state_e;
  state_e st_q;
  logic ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ov_q <= 1'b0;
    end else begin
      case (st_q)
        StIdle: if (in_valid_i) st_q <= StLoad;
        StLoad: st_q <= sts_i.is_open ? StOpen : StPvA;
        StOpen: st_q <= StFin;
        StPvA: st_q <= StPvB;
        StPvB: st_q <= StPvR;
        StPvR: st_q <= StErr;
        StErr: st_q <= StPMul;
        StPMul: st_q <= StLoSt;
        StLoSt: st_q <= StLoW;
        StLoW: if (!sts_i.div_busy) st_q <= StHiSt;
        StHiSt: st_q <= StHiW;
        StHiW: if (!sts_i.div_busy) st_q <= StInt;
        StInt: st_q <= StIMul;
        StIMul: st_q <= StDSt;
        StDSt: st_q <= StDW;
        StDW: if (!sts_i.div_busy) st_q <= StDB;
        StDB: st_q <= StSmooth;
        StSmooth: st_q <= StFin;
        StFin: begin st_q <= StOut; ov_q <= 1'b1; end
        StOut: if (out_ready_i) begin st_q <= StIdle; ov_q <= 1'b0; end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.op = pidsa_pkg::OpIdle;
    cmd_o.mul_a = 1'b0;
    case (st_q)
      StIdle: if (in_valid_i) cmd_o.op = pidsa_pkg::OpLoad;
      StOpen: cmd_o.op = pidsa_pkg::OpOpen;
      StPvA: begin cmd_o.op = pidsa_pkg::OpPvMul; cmd_o.mul_a = 1'b1; end
      StPvB: cmd_o.op = pidsa_pkg::OpPvMul;
      StPvR: cmd_o.op = pidsa_pkg::OpPvRnd;
      StErr: cmd_o.op = pidsa_pkg::OpErr;
      StPMul: cmd_o.op = pidsa_pkg::OpPMul;
      StLoSt: cmd_o.op = pidsa_pkg::OpLoDivSt;
      StLoW: if (!sts_i.div_busy) cmd_o.op = pidsa_pkg::OpLoDivEnd;
      StHiSt: cmd_o.op = pidsa_pkg::OpHiDivSt;
      StHiW: if (!sts_i.div_busy) cmd_o.op = pidsa_pkg::OpHiDivEnd;
      StInt: cmd_o.op = pidsa_pkg::OpIntUpd;
      StIMul: cmd_o.op = pidsa_pkg::OpIMul;
      StDSt: cmd_o.op = pidsa_pkg::OpDDivSt;
      StDW: if (!sts_i.div_busy) begin cmd_o.op = pidsa_pkg::OpDDivEnd; cmd_o.mul_a = 1'b1; end
      StDB: cmd_o.op = pidsa_pkg::OpDDivEnd;
      StSmooth: cmd_o.op = pidsa_pkg::OpFinish;
      StFin: begin cmd_o.op = pidsa_pkg::OpFinish; cmd_o.mul_a = 1'b1; end
      default: ;
    endcase
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = ov_q;

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !in_ready_o) else $error("input taken while word held");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q == (st_q == StOut)) else $error("valid out of step");
  a_fin_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFin) |=> ov_q) else $error("result lost");
`endif
endmodule

>>> rtl/pid_controller_smoothed_antiwindup_core.sv
// open-loop words go load, open, finish, output; closed-loop words also wait three times
// on the shared serial divider (low limit, high limit, derivative)
// throughput: one word in flight, next accepted the cycle after the result is taken
// reset: asynchronous active low; gains, limits and weights return to their
// defaults and the controller state (smoothed values, integral) is cleared
module pid_controller_smoothed_antiwindup_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // setpoint, measured, time_step, limit_dir, open_loop, open_loop_value
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive, p_term, i_term, d_term
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  logic [31:0] kp_q, ki_q, kd_q, omin_q, omax_q;
  logic [16:0] pvw_q, dw_q;
  logic        inv_q;
  pidsa_pkg::cmd_t cmd;
  pidsa_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= 32'h0001_0000; ki_q <= '0; kd_q <= '0;
      omin_q <= 32'hffff_0000; omax_q <= 32'h0001_0000;
      pvw_q <= 17'h10000; dw_q <= 17'h10000; inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidsa_pkg::RegKp: kp_q <= cfg_data_i;
        pidsa_pkg::RegKi: ki_q <= cfg_data_i;
        pidsa_pkg::RegKd: kd_q <= cfg_data_i;
        pidsa_pkg::RegOutMin: omin_q <= cfg_data_i;
        pidsa_pkg::RegOutMax: omax_q <= cfg_data_i;
        pidsa_pkg::RegPvW: pvw_q <= cfg_data_i[16:0];
        pidsa_pkg::RegDerivW: dw_q <= cfg_data_i[16:0];
        pidsa_pkg::RegInvert: inv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pidsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  // datapath holds state, shared multiplier and serial divider
  pidsa_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kp_i(kp_q), .ki_i(ki_q), .kd_i(kd_q), .omin_i(omin_q), .omax_i(omax_q),
    .pvw_i(pvw_q), .dw_i(dw_q), .inv_i(inv_q),
    .in_i(s_axis_tdata[129:0]),
    .res_o(m_axis_tdata)
  );
endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // input word layout: setpoint, measured, time_step, limit_dir, open_loop, open_loop_value
  typedef struct {
    logic signed [31:0] sp;
    logic signed [31:0] pv;
    logic [30:0]        dt;
    logic signed [1:0]  lim;
    logic               open;
    logic signed [31:0] olv;
  } tick_t;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] p;
    logic signed [31:0] i;
    logic signed [31:0] d;
  } ctl_out_t;

  // one row of the directed table: the tick, and an optional typed-in answer
  typedef struct {
    tick_t    tk;
    logic     known;
    ctl_out_t want;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  pid_controller_smoothed_antiwindup_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the gains and controller state
  longint kp, ki, kd, out_lo, out_hi;
  int unsigned pv_w, d_w;
  bit invert;
  longint pv_sm, last_err, integ, d_sm;
  bit was_open;

  ctl_out_t expected_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;   // idle chance in percent
  bit recv_hold = 0;                  // long back-pressure stretch
  int quiet = 0;
  localparam int QuietLimit = 20000;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // round half up to q16.16 with floor semantics
  function automatic longint round16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint blend(longint cur, longint prev, int unsigned w);
    longint wt;
    wt = (w > 65536) ? 65536 : w;
    return round16(wt * cur + (65536 - wt) * prev);
  endfunction

  // low limit checked first: with crossed limits, x below lo gives lo, anything else gives hi
  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x < hi) return x;
    return hi;
  endfunction

  function automatic longint qdiv(longint num, longint den);
    if (den == 0) return 0;
    return sat32((num * 65536) / den);
  endfunction

  function automatic ctl_out_t pid_tick(tick_t tk);
    ctl_out_t r;
    longint dt, lim, err, p, i, d, lo, hi, sum, drv;
    dt = tk.dt;
    lim = tk.lim;
    if (lim < -1) lim = -1;
    if (dt == 0) dt = 1;
    if (tk.open) begin
      // entry into open loop re-seeds the state
      if (!was_open) begin
        pv_sm = tk.pv;
        d_sm = 0;
        integ = last_err;
      end
      was_open = 1;
      r.drive = tk.olv;
      r.p = 0;
      r.i = 0;
      r.d = 0;
      return r;
    end
    was_open = 0;
    pv_sm = blend(tk.pv, pv_sm, pv_w);
    err = sat32(tk.sp - pv_sm);
    p = sat32(round16(kp * err));
    // anti-windup: hold the integral while limit, error and integral agree in sign
    if (!(lim * err > 0 && lim * integ > 0)) begin
      lo = qdiv(out_lo, ki);
      hi = qdiv(out_hi, ki);
      integ = clamp(round16(dt * err) + integ, lo, hi);
    end
    i = sat32(round16(ki * integ));
    d = sat32((kd * (err - last_err)) / (2 * dt));
    d_sm = blend(d, d_sm, d_w);
    sum = p + i + d_sm;
    drv = clamp(sum, out_lo, out_hi);
    if (invert) drv = sat32(-drv);
    last_err = err;
    r.drive = drv[31:0];
    r.p = p[31:0];
    r.i = i[31:0];
    r.d = d_sm[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pidsa_pkg::RegKp:     kp = longint'(signed'(val));
      pidsa_pkg::RegKi:     ki = longint'(signed'(val));
      pidsa_pkg::RegKd:     kd = longint'(signed'(val));
      pidsa_pkg::RegOutMin: out_lo = longint'(signed'(val));
      pidsa_pkg::RegOutMax: out_hi = longint'(signed'(val));
      pidsa_pkg::RegPvW:    pv_w = val[16:0];
      pidsa_pkg::RegDerivW: d_w = val[16:0];
      default:              invert = val[0];
    endcase
  endtask

  // sender: offer one word, hold it until taken, maybe idle first
  task automatic send_word(tick_t tk);
    @(negedge clk_i);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    s_axis_tdata <= {tk.olv, tk.open, tk.lim, tk.dt, tk.pv, tk.sp};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(pid_tick(tk));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic tick_t rand_tick(int open_pct);
    tick_t t;
    int sel;
    sel = $urandom_range(9);
    t.sp = (sel < 6) ? 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19)) : $urandom();
    t.pv = (sel < 6) ? t.sp + 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17))
                     : $urandom();
    t.dt = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 1 << 17));
    if ($urandom_range(15) == 0) t.dt = 0;
    t.lim = 2'($urandom());
    t.open = ($urandom_range(99) < open_pct);
    t.olv = $urandom();
    return t;
  endfunction

  function automatic tick_t mk(int sp, int pv, int dt, int lim, bit op, int olv);
    tick_t t;
    t.sp = sp;
    t.pv = pv;
    t.dt = 31'(dt);
    t.lim = 2'(lim);
    t.open = op;
    t.olv = olv;
    return t;
  endfunction

  // receiver with random stalls and an optional long hold-off
  always @(negedge clk_i) begin
    if (recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // checker, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], 32'h0);
      end else begin
        ctl_out_t w;
        w = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== w.drive) report_mismatch("drive", m_axis_tdata[31:0], w.drive);
        if (m_axis_tdata[63:32] !== w.p) report_mismatch("p_term", m_axis_tdata[63:32], w.p);
        if (m_axis_tdata[95:64] !== w.i) report_mismatch("i_term", m_axis_tdata[95:64], w.i);
        if (m_axis_tdata[127:96] !== w.d) report_mismatch("d_term", m_axis_tdata[127:96], w.d);
      end
    end
  end

  // watchdog: cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t dir[$];

  initial begin
    row_t rw;
    kp = 65536; ki = 0; kd = 0; out_lo = -65536; out_hi = 65536;
    pv_w = 65536; d_w = 65536; invert = 0;
    pv_sm = 0; last_err = 0; integ = 0; d_sm = 0; was_open = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed part; answers typed in where they follow from the defaults
    rw.known = 1; rw.tk = mk(0, 0, 65536, 0, 0, 0);
    rw.want = '{0, 0, 0, 0}; dir.push_back(rw);
    rw.tk = mk(32768, 0, 65536, 0, 0, 0);
    rw.want = '{32768, 32768, 0, 0}; dir.push_back(rw);
    rw.tk = mk(32'h7fffffff, 0, 65536, 0, 0, 0);  // saturated p, clamped drive
    rw.want = '{65536, 32'h7fffffff, 0, 0}; dir.push_back(rw);
    rw.tk = mk(32'h80000000, 0, 65536, 0, 0, 0);
    rw.want = '{-65536, 32'h80000000, 0, 0}; dir.push_back(rw);
    rw.tk = mk(0, 0, 1, 0, 1, 32'h7fffffff);        // open-loop pass-through
    rw.want = '{32'h7fffffff, 0, 0, 0}; dir.push_back(rw);
    rw.tk = mk(0, 0, 1, 0, 1, 32'h80000000);
    rw.want = '{32'h80000000, 0, 0, 0}; dir.push_back(rw);
    rw.known = 0;
    dir.push_back('{mk(100, 5, 0, -2, 0, 0), 0, '{0, 0, 0, 0}});           // zero step, lim -2
    dir.push_back('{mk(-70000, 3, 32'h7fffffff, 1, 0, -1), 0, '{0, 0, 0, 0}});
    dir.push_back('{mk(70000, -3, 1, -1, 0, 5), 0, '{0, 0, 0, 0}});
    foreach (dir[k]) begin
      send_word(dir[k].tk);
      if (dir[k].known) begin
        expected_q[$] = dir[k].want;
      end
    end
    drain();

    // gains active, smoothing, inversion, limits far apart
    write_reg(pidsa_pkg::RegKp, 32'h0002_0000);
    write_reg(pidsa_pkg::RegKi, 32'h0000_8000);
    write_reg(pidsa_pkg::RegKd, 32'h0001_0000);
    write_reg(pidsa_pkg::RegOutMin, 32'hfff0_0000);
    write_reg(pidsa_pkg::RegOutMax, 32'h0010_0000);
    write_reg(pidsa_pkg::RegPvW, 32'd16384);
    write_reg(pidsa_pkg::RegDerivW, 32'd40000);
    write_reg(pidsa_pkg::RegInvert, 32'd1);
    for (int k = 0; k < 12; k++) send_word(rand_tick(15));
    drain();

    // extremes: negative ki, crossed limits, pv weight above one, zero derivative weight, huge gains
    write_reg(pidsa_pkg::RegKp, 32'h8000_0000);
    write_reg(pidsa_pkg::RegKi, 32'hffff_0000);
    write_reg(pidsa_pkg::RegKd, 32'h7fff_ffff);
    write_reg(pidsa_pkg::RegOutMin, 32'h7fff_ffff);
    write_reg(pidsa_pkg::RegOutMax, 32'h8000_0000);
    write_reg(pidsa_pkg::RegPvW, 32'h1_ffff);
    write_reg(pidsa_pkg::RegDerivW, 32'd0);
    for (int k = 0; k < 10; k++) send_word(rand_tick(10));
    drain();

    // random phases with varied settings and idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 30 : 0;
      write_reg(pidsa_pkg::RegKp, (ph == 2) ? $urandom() : $urandom_range(0, 1 << 19));
      write_reg(pidsa_pkg::RegKi, (ph == 1) ? $urandom() : $urandom_range(1, 1 << 17));
      write_reg(pidsa_pkg::RegKd, $urandom_range(0, 1 << 18));
      write_reg(pidsa_pkg::RegOutMin, 32'(-signed'($urandom_range(1, 1 << 24))));
      write_reg(pidsa_pkg::RegOutMax, $urandom_range(1, 1 << 24));
      write_reg(pidsa_pkg::RegPvW, $urandom_range(0, 65536));
      write_reg(pidsa_pkg::RegDerivW, $urandom_range(0, 65536));
      write_reg(pidsa_pkg::RegInvert, $urandom_range(1));
      for (int k = 0; k < 160; k++) begin
        if (ph == 2 && k == 40) begin
          // long receiver hold-off while the sender keeps offering
          fork
            begin
              recv_hold = 1;
              repeat (1500) @(negedge clk_i);
              recv_hold = 0;
            end
          join_none
        end
        if (k == 100) begin
          // sender pause until everything is back
          while (expected_q.size() != 0) @(negedge clk_i);
        end
        send_word(rand_tick(10));
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pidsa_pkg.sv
rtl/pidsa_div.sv
rtl/pidsa_dp.sv
rtl/pidsa_ctrl.sv
rtl/pid_controller_smoothed_antiwindup_core.sv
test/testbench.sv
